/* src/ltm_telemetry_frame_parser_top_assert.svh */
// assertion macros shared by the parser rtl
`ifndef LTM_TELEMETRY_FRAME_PARSER_TOP_ASSERT_SVH
`define LTM_TELEMETRY_FRAME_PARSER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF

// condition must hold whenever reset is released
`define LTM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// trigger in a cycle implies consequence in the next
`define LTM_ASSERT_NEXT(label, clk, rstn, trig, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (trig) |=> (cons)) \
        else $error(msg);

`else

`define LTM_ASSERT(label, clk, rstn, prop, msg)
`define LTM_ASSERT_NEXT(label, clk, rstn, trig, cons, msg)

`endif

`endif

/* src/ltm_pkg.sv */
package ltm_pkg;

    // payload store depth
    localparam int MAX_PAYLOAD = 14;
    localparam int POS_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);

    // highest payload byte any field looks at, plus one
    localparam int FIELD_BYTES = 14;

    // configuration port
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CMP_W     = (POS_W > CFG_W) ? POS_W : CFG_W;

    localparam logic [CFG_IDX_W-1:0] REG_GPS_LEN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTITUDE_LEN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSOR_LEN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_LEN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NAV_LEN      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_EXTRA_LEN    = 3'd5;

    localparam logic [CFG_W-1:0] RST_GPS_LEN      = 4'd14;
    localparam logic [CFG_W-1:0] RST_ATTITUDE_LEN = 4'd6;
    localparam logic [CFG_W-1:0] RST_SENSOR_LEN   = 4'd7;
    localparam logic [CFG_W-1:0] RST_ORIGIN_LEN   = 4'd14;
    localparam logic [CFG_W-1:0] RST_NAV_LEN      = 4'd6;
    localparam logic [CFG_W-1:0] RST_EXTRA_LEN    = 4'd6;

    // parser phases
    localparam int PHASE_W = 2;
    localparam logic [PHASE_W-1:0] PH_HUNT   = 2'd0;
    localparam logic [PHASE_W-1:0] PH_T      = 2'd1;
    localparam logic [PHASE_W-1:0] PH_LETTER = 2'd2;
    localparam logic [PHASE_W-1:0] PH_DATA   = 2'd3;

    // frame kinds
    localparam int KIND_W = 3;
    localparam logic [KIND_W-1:0] KIND_G = 3'd0;
    localparam logic [KIND_W-1:0] KIND_A = 3'd1;
    localparam logic [KIND_W-1:0] KIND_S = 3'd2;
    localparam logic [KIND_W-1:0] KIND_O = 3'd3;
    localparam logic [KIND_W-1:0] KIND_X = 3'd4;
    localparam logic [KIND_W-1:0] KIND_N = 3'd5;

    // stream characters
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_T      = 8'h54;
    localparam logic [7:0] CHAR_G      = 8'h47;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_O      = 8'h4F;
    localparam logic [7:0] CHAR_N      = 8'h4E;
    localparam logic [7:0] CHAR_X      = 8'h58;

    localparam logic signed [31:0] HEADING_WRAP = 32'sd360;

    typedef logic [MAX_PAYLOAD-1:0][7:0] store_t;

    // frame descriptor handed to the unpacker
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  len;
    } frame_t;

    // one result item
    typedef struct packed {
        logic [KIND_W-1:0] frame_kind;
        logic signed [31:0] word_a;
        logic signed [31:0] word_b;
        logic signed [31:0] word_c;
        logic [7:0]        byte_a;
        logic [7:0]        byte_b;
        logic [5:0]        mode_bits;
        logic              armed_flag;
        logic              failsafe_flag;
        logic              render_hint;
    } result_t;

endpackage

/* src/ltm_field_unpack.sv */
module ltm_field_unpack (
    input  ltm_pkg::frame_t  frame,
    input  ltm_pkg::store_t  store,
    output ltm_pkg::result_t result
);

    logic [7:0]  pm [ltm_pkg::FIELD_BYTES];
    logic [15:0] heading;

    // bytes past the frame length read as zero
    for (genvar i = 0; i < ltm_pkg::FIELD_BYTES; i++) begin : g_mask
        if (i < ltm_pkg::MAX_PAYLOAD) begin : g_byte
            assign pm[i] = (ltm_pkg::POS_W'(i) < frame.len) ? store[i] : 8'h00;
        end else begin : g_none
            assign pm[i] = 8'h00;
        end
    end

    assign heading = {pm[5], pm[4]};

    always_comb begin
        result            = '0;
        result.frame_kind = frame.kind;
        unique case (frame.kind)
            ltm_pkg::KIND_G: begin
                result.word_a    = {pm[3], pm[2], pm[1], pm[0]};
                result.word_b    = {pm[7], pm[6], pm[5], pm[4]};
                result.word_c    = {pm[12], pm[11], pm[10], pm[9]};
                result.byte_a    = pm[8];
                result.byte_b    = {2'b00, pm[13][7:2]};
                result.mode_bits = {4'b0000, pm[13][1:0]};
            end
            ltm_pkg::KIND_A: begin
                result.word_a      = {{16{pm[1][7]}}, pm[1], pm[0]};
                result.word_b      = {{16{pm[3][7]}}, pm[3], pm[2]};
                result.word_c      = {{16{heading[15]}}, heading};
                if (heading[15]) begin
                    result.word_c = result.word_c + ltm_pkg::HEADING_WRAP;
                end
                result.render_hint = 1'b1;
            end
            ltm_pkg::KIND_S: begin
                result.word_a        = {16'h0000, pm[1], pm[0]};
                result.word_b        = {16'h0000, pm[3], pm[2]};
                result.byte_a        = pm[4];
                result.byte_b        = pm[5];
                result.mode_bits     = pm[6][7:2];
                result.armed_flag    = pm[6][0];
                result.failsafe_flag = pm[6][1];
            end
            ltm_pkg::KIND_O: begin
                result.word_a = {pm[3], pm[2], pm[1], pm[0]};
                result.word_b = {pm[7], pm[6], pm[5], pm[4]};
                result.word_c = {pm[11], pm[10], pm[9], pm[8]};
                result.byte_a = pm[12];
                result.byte_b = pm[13];
            end
            ltm_pkg::KIND_X: begin
                result.word_a = {16'h0000, pm[1], pm[0]};
            end
            default: begin
                result.frame_kind = frame.kind;
            end
        endcase
    end

endmodule

/* src/ltm_telemetry_frame_parser_top.sv */
// LTM telemetry frame parser. One byte of the serial stream is taken per
// transfer on the s_ channel, and a new byte can be taken every cycle. The
// parser hunts for '$' 'T' and a frame letter (G, A, S, O, N or X), collects
// the payload whose length comes from the per-letter length register, and
// checks the XOR over payload and check byte. A good G, A, S, O or X frame
// gives one result transfer on the m_ channel, registered in the output or
// skid register; N frames and bad checksums give nothing. The parse state and
// the payload store are updated in the same cycle as the byte, and the result
// is formed from the payload store by one level of field selection into the
// output register. A two-entry output buffer (output register plus skid
// register) lets the parser keep taking bytes while a result waits; s_ready
// drops only when both entries hold results. Write length registers through
// cfg_wr_en/cfg_index/cfg_data only while the parser is idle (not enforced).
`include "ltm_telemetry_frame_parser_top_assert.svh"

module ltm_telemetry_frame_parser_top (
    input  logic                            aclk,
    input  logic                            aresetn,

    // configuration writes
    input  logic                            cfg_wr_en,
    input  logic [ltm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ltm_pkg::CFG_W-1:0]       cfg_data,

    // byte stream in
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [7:0]                      s_rx_byte,

    // decoded frames out
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [ltm_pkg::KIND_W-1:0]      m_frame_kind,
    output logic signed [31:0]              m_word_a,
    output logic signed [31:0]              m_word_b,
    output logic signed [31:0]              m_word_c,
    output logic [7:0]                      m_byte_a,
    output logic [7:0]                      m_byte_b,
    output logic [5:0]                      m_mode_bits,
    output logic                            m_armed_flag,
    output logic                            m_failsafe_flag,
    output logic                            m_render_hint
);

    // length registers
    logic [ltm_pkg::CFG_W-1:0] gps_len_reg;
    logic [ltm_pkg::CFG_W-1:0] att_len_reg;
    logic [ltm_pkg::CFG_W-1:0] sen_len_reg;
    logic [ltm_pkg::CFG_W-1:0] org_len_reg;
    logic [ltm_pkg::CFG_W-1:0] nav_len_reg;
    logic [ltm_pkg::CFG_W-1:0] ext_len_reg;

    // parse state
    logic [ltm_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [ltm_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [7:0]                  xor_reg, xor_next;
    logic [ltm_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [ltm_pkg::POS_W-1:0]   len_reg, len_next;
    ltm_pkg::store_t             store_reg;

    // output buffer
    logic             out_valid_reg;
    ltm_pkg::result_t out_data_reg;
    logic             skid_valid_reg;
    ltm_pkg::result_t skid_data_reg;

    logic                        in_xfer;
    logic                        store_we;
    logic                        result_fire;
    logic                        letter_ok;
    logic [ltm_pkg::KIND_W-1:0]  letter_kind;
    logic [ltm_pkg::CFG_W-1:0]   letter_cfg;
    logic [ltm_pkg::CMP_W-1:0]   letter_cfg_ext;
    ltm_pkg::frame_t             frame;
    ltm_pkg::result_t            result;

    assign s_ready = !skid_valid_reg;
    assign in_xfer = s_valid && s_ready;

    // frame letter decode and its length register
    always_comb begin
        letter_ok   = 1'b1;
        letter_kind = ltm_pkg::KIND_G;
        letter_cfg  = gps_len_reg;
        unique case (s_rx_byte)
            ltm_pkg::CHAR_G: begin
                letter_kind = ltm_pkg::KIND_G;
                letter_cfg  = gps_len_reg;
            end
            ltm_pkg::CHAR_A: begin
                letter_kind = ltm_pkg::KIND_A;
                letter_cfg  = att_len_reg;
            end
            ltm_pkg::CHAR_S: begin
                letter_kind = ltm_pkg::KIND_S;
                letter_cfg  = sen_len_reg;
            end
            ltm_pkg::CHAR_O: begin
                letter_kind = ltm_pkg::KIND_O;
                letter_cfg  = org_len_reg;
            end
            ltm_pkg::CHAR_N: begin
                letter_kind = ltm_pkg::KIND_N;
                letter_cfg  = nav_len_reg;
            end
            ltm_pkg::CHAR_X: begin
                letter_kind = ltm_pkg::KIND_X;
                letter_cfg  = ext_len_reg;
            end
            default: begin
                letter_ok = 1'b0;
            end
        endcase
    end

    // lengths above the store depth saturate
    assign letter_cfg_ext = ltm_pkg::CMP_W'(letter_cfg);

    // parser next state
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        xor_next    = xor_reg;
        kind_next   = kind_reg;
        len_next    = len_reg;
        store_we    = 1'b0;
        result_fire = 1'b0;
        if (in_xfer) begin
            unique case (phase_reg)
                ltm_pkg::PH_HUNT: begin
                    phase_next = (s_rx_byte == ltm_pkg::CHAR_DOLLAR) ? ltm_pkg::PH_T
                                                                     : ltm_pkg::PH_HUNT;
                end
                ltm_pkg::PH_T: begin
                    phase_next = (s_rx_byte == ltm_pkg::CHAR_T) ? ltm_pkg::PH_LETTER
                                                                : ltm_pkg::PH_HUNT;
                end
                ltm_pkg::PH_LETTER: begin
                    if (letter_ok) begin
                        phase_next = ltm_pkg::PH_DATA;
                        kind_next  = letter_kind;
                        pos_next   = '0;
                        xor_next   = '0;
                        if (letter_cfg_ext > ltm_pkg::CMP_W'(ltm_pkg::MAX_PAYLOAD)) begin
                            len_next = ltm_pkg::POS_W'(ltm_pkg::MAX_PAYLOAD);
                        end else begin
                            len_next = ltm_pkg::POS_W'(letter_cfg_ext);
                        end
                    end else begin
                        phase_next = ltm_pkg::PH_HUNT;
                    end
                end
                default: begin
                    xor_next = xor_reg ^ s_rx_byte;
                    if (pos_reg >= len_reg) begin
                        // check byte: a zero xor over the frame accepts it
                        phase_next  = ltm_pkg::PH_HUNT;
                        result_fire = (xor_next == 8'h00) && (kind_reg != ltm_pkg::KIND_N);
                    end else begin
                        store_we = 1'b1;
                        pos_next = pos_reg + ltm_pkg::POS_W'(1);
                    end
                end
            endcase
        end
    end

    // fields come from the payload as it stands when the check byte arrives
    assign frame.kind = kind_reg;
    assign frame.len  = len_reg;

    ltm_field_unpack u_unpack (
        .frame  (frame),
        .store  (store_reg),
        .result (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gps_len_reg <= ltm_pkg::RST_GPS_LEN;
            att_len_reg <= ltm_pkg::RST_ATTITUDE_LEN;
            sen_len_reg <= ltm_pkg::RST_SENSOR_LEN;
            org_len_reg <= ltm_pkg::RST_ORIGIN_LEN;
            nav_len_reg <= ltm_pkg::RST_NAV_LEN;
            ext_len_reg <= ltm_pkg::RST_EXTRA_LEN;
        end else if (cfg_wr_en) begin
            // indexes past the last register are dropped
            unique case (cfg_index)
                ltm_pkg::REG_GPS_LEN:      gps_len_reg <= cfg_data;
                ltm_pkg::REG_ATTITUDE_LEN: att_len_reg <= cfg_data;
                ltm_pkg::REG_SENSOR_LEN:   sen_len_reg <= cfg_data;
                ltm_pkg::REG_ORIGIN_LEN:   org_len_reg <= cfg_data;
                ltm_pkg::REG_NAV_LEN:      nav_len_reg <= cfg_data;
                ltm_pkg::REG_EXTRA_LEN:    ext_len_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ltm_pkg::PH_HUNT;
            pos_reg   <= '0;
            xor_reg   <= '0;
            kind_reg  <= ltm_pkg::KIND_G;
            len_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            xor_reg   <= xor_next;
            kind_reg  <= kind_next;
            len_reg   <= len_next;
        end
    end

    // payload store, written only below the frame length
    always_ff @(posedge aclk) begin
        if (store_we) begin
            store_reg[pos_reg[ltm_pkg::IDX_W-1:0]] <= s_rx_byte;
        end
    end

    // output buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_valid_reg && !m_ready) begin
            // output stalled: a new result parks in the skid register
            if (result_fire) begin
                skid_valid_reg <= 1'b1;
            end
        end else if (skid_valid_reg) begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= result_fire;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_valid_reg && !m_ready) begin
            if (result_fire) begin
                skid_data_reg <= result;
            end
        end else if (skid_valid_reg) begin
            out_data_reg <= skid_data_reg;
        end else if (result_fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_frame_kind    = out_data_reg.frame_kind;
    assign m_word_a        = out_data_reg.word_a;
    assign m_word_b        = out_data_reg.word_b;
    assign m_word_c        = out_data_reg.word_c;
    assign m_byte_a        = out_data_reg.byte_a;
    assign m_byte_b        = out_data_reg.byte_b;
    assign m_mode_bits     = out_data_reg.mode_bits;
    assign m_armed_flag    = out_data_reg.armed_flag;
    assign m_failsafe_flag = out_data_reg.failsafe_flag;
    assign m_render_hint   = out_data_reg.render_hint;

    // skid entry exists only behind a held output entry
    `LTM_ASSERT(a_skid_behind_out, aclk, aresetn, !skid_valid_reg || out_valid_reg,
        "skid register valid while output register empty")

    // a result against a stalled output must land in the skid register
    `LTM_ASSERT_NEXT(a_stall_to_skid, aclk, aresetn,
        result_fire && out_valid_reg && !m_ready, skid_valid_reg,
        "result lost while output stalled")

    // position never runs past the frame length
    `LTM_ASSERT(a_pos_in_frame, aclk, aresetn,
        (phase_reg != ltm_pkg::PH_DATA) || (pos_reg <= len_reg),
        "payload position beyond frame length")

    // frame length never exceeds the store
    `LTM_ASSERT(a_len_in_store, aclk, aresetn,
        ltm_pkg::CMP_W'(len_reg) <= ltm_pkg::CMP_W'(ltm_pkg::MAX_PAYLOAD),
        "frame length beyond payload store")

    // render hint only on attitude frames, never on nav frames
    `LTM_ASSERT(a_hint_kind, aclk, aresetn,
        !out_valid_reg || ((!m_render_hint || m_frame_kind == ltm_pkg::KIND_A)
                           && m_frame_kind != ltm_pkg::KIND_N),
        "bad frame kind on output transfer")

endmodule

/* verif/tb_top.sv */
module tb_top;

    // clocking and run length
    localparam int HALF_PERIOD       = 10;
    localparam int RESET_CYCLES      = 9;
    localparam int SETTLE_CYCLES     = 8;
    localparam int TIMEOUT_CYCLES    = 200000;

    // stimulus shape
    localparam int FRAME_BYTE_BUDGET = 1650;
    localparam int PHASE_COUNT       = 9;
    localparam int STEADY_PHASE      = 4;
    localparam int IDLE_PERCENT      = 8;
    localparam int GOOD_PERCENT      = 80;
    localparam int SPOIL_PERCENT     = 12;
    localparam int SHOWN_MISMATCHES  = 10;

    // indexes past the last length register, writes there must be ignored
    localparam logic [ltm_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ltm_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    // a byte that is no frame letter
    localparam logic [7:0] CHAR_BOGUS = 8'h5A;

    // tracks the byte stream and holds the decoded frames still owed by the dut
    class ltm_frame_tracker;
        logic [ltm_pkg::CFG_W-1:0]   len_reg [6];
        logic [ltm_pkg::PHASE_W-1:0] phase;
        logic [7:0]                  store [ltm_pkg::MAX_PAYLOAD];
        int                          pos;
        int                          flen;
        logic [7:0]                  xsum;
        logic [ltm_pkg::KIND_W-1:0]  kind;
        ltm_pkg::result_t            due_frames [$];
        int                          mismatches;

        function new();
            len_reg[ltm_pkg::REG_GPS_LEN]      = ltm_pkg::RST_GPS_LEN;
            len_reg[ltm_pkg::REG_ATTITUDE_LEN] = ltm_pkg::RST_ATTITUDE_LEN;
            len_reg[ltm_pkg::REG_SENSOR_LEN]   = ltm_pkg::RST_SENSOR_LEN;
            len_reg[ltm_pkg::REG_ORIGIN_LEN]   = ltm_pkg::RST_ORIGIN_LEN;
            len_reg[ltm_pkg::REG_NAV_LEN]      = ltm_pkg::RST_NAV_LEN;
            len_reg[ltm_pkg::REG_EXTRA_LEN]    = ltm_pkg::RST_EXTRA_LEN;
            foreach (store[i]) store[i] = 8'h00;
            phase      = ltm_pkg::PH_HUNT;
            pos        = 0;
            flen       = 0;
            xsum       = 8'h00;
            kind       = ltm_pkg::KIND_G;
            mismatches = 0;
        endfunction

        function void set_len(logic [ltm_pkg::CFG_IDX_W-1:0] idx,
                              logic [ltm_pkg::CFG_W-1:0] val);
            if (idx <= ltm_pkg::REG_EXTRA_LEN) len_reg[idx] = val;
        endfunction

        function bit decode_letter(logic [7:0] b, output logic [ltm_pkg::KIND_W-1:0] k);
            bit hit;
            hit = 1'b1;
            k   = ltm_pkg::KIND_G;
            case (b)
                ltm_pkg::CHAR_G: k = ltm_pkg::KIND_G;
                ltm_pkg::CHAR_A: k = ltm_pkg::KIND_A;
                ltm_pkg::CHAR_S: k = ltm_pkg::KIND_S;
                ltm_pkg::CHAR_O: k = ltm_pkg::KIND_O;
                ltm_pkg::CHAR_N: k = ltm_pkg::KIND_N;
                ltm_pkg::CHAR_X: k = ltm_pkg::KIND_X;
                default:         hit = 1'b0;
            endcase
            return hit;
        endfunction

        // payload length for a kind, clipped to the store depth
        function int len_of_kind(logic [ltm_pkg::KIND_W-1:0] k);
            int r;
            case (k)
                ltm_pkg::KIND_G: r = len_reg[ltm_pkg::REG_GPS_LEN];
                ltm_pkg::KIND_A: r = len_reg[ltm_pkg::REG_ATTITUDE_LEN];
                ltm_pkg::KIND_S: r = len_reg[ltm_pkg::REG_SENSOR_LEN];
                ltm_pkg::KIND_O: r = len_reg[ltm_pkg::REG_ORIGIN_LEN];
                ltm_pkg::KIND_N: r = len_reg[ltm_pkg::REG_NAV_LEN];
                default:         r = len_reg[ltm_pkg::REG_EXTRA_LEN];
            endcase
            if (r > ltm_pkg::MAX_PAYLOAD) r = ltm_pkg::MAX_PAYLOAD;
            return r;
        endfunction

        function int frame_len(logic [7:0] letter);
            logic [ltm_pkg::KIND_W-1:0] k;
            if (!decode_letter(letter, k)) return 0;
            return len_of_kind(k);
        endfunction

        // bytes past the frame length read as zero
        function logic [7:0] pb(int i);
            if (i < flen && i < ltm_pkg::MAX_PAYLOAD) return store[i];
            return 8'h00;
        endfunction

        function logic [15:0] p16(int i);
            return {pb(i + 1), pb(i)};
        endfunction

        function logic [31:0] p32(int i);
            return {p16(i + 2), p16(i)};
        endfunction

        function ltm_pkg::result_t decode_frame();
            ltm_pkg::result_t   r;
            logic signed [31:0] hd;
            logic [7:0]         b6;
            logic [7:0]         b13;
            logic [15:0]        h0;
            logic [15:0]        h2;
            logic [15:0]        h4;
            r   = '0;
            b6  = pb(6);
            b13 = pb(13);
            h0  = p16(0);
            h2  = p16(2);
            h4  = p16(4);
            r.frame_kind = kind;
            case (kind)
                ltm_pkg::KIND_G: begin
                    r.word_a    = p32(0);
                    r.word_b    = p32(4);
                    r.word_c    = p32(9);
                    r.byte_a    = pb(8);
                    r.byte_b    = {2'b00, b13[7:2]};
                    r.mode_bits = {4'b0000, b13[1:0]};
                end
                ltm_pkg::KIND_A: begin
                    r.word_a = {{16{h0[15]}}, h0};
                    r.word_b = {{16{h2[15]}}, h2};
                    hd       = {{16{h4[15]}}, h4};
                    // negative heading wraps into the positive range
                    if (hd < 0) hd = hd + ltm_pkg::HEADING_WRAP;
                    r.word_c      = hd;
                    r.render_hint = 1'b1;
                end
                ltm_pkg::KIND_S: begin
                    r.word_a        = {16'h0000, h0};
                    r.word_b        = {16'h0000, h2};
                    r.byte_a        = pb(4);
                    r.byte_b        = pb(5);
                    r.mode_bits     = b6[7:2];
                    r.armed_flag    = b6[0];
                    r.failsafe_flag = b6[1];
                end
                ltm_pkg::KIND_O: begin
                    r.word_a = p32(0);
                    r.word_b = p32(4);
                    r.word_c = p32(8);
                    r.byte_a = pb(12);
                    r.byte_b = b13;
                end
                default: r.word_a = {16'h0000, h0};
            endcase
            return r;
        endfunction

        // one accepted stream byte
        function void take_byte(logic [7:0] b);
            logic [ltm_pkg::KIND_W-1:0] k;
            case (phase)
                ltm_pkg::PH_HUNT: begin
                    phase = (b == ltm_pkg::CHAR_DOLLAR) ? ltm_pkg::PH_T : ltm_pkg::PH_HUNT;
                end
                ltm_pkg::PH_T: begin
                    phase = (b == ltm_pkg::CHAR_T) ? ltm_pkg::PH_LETTER : ltm_pkg::PH_HUNT;
                end
                ltm_pkg::PH_LETTER: begin
                    if (decode_letter(b, k)) begin
                        kind  = k;
                        flen  = len_of_kind(k);
                        pos   = 0;
                        xsum  = 8'h00;
                        phase = ltm_pkg::PH_DATA;
                    end else begin
                        phase = ltm_pkg::PH_HUNT;
                    end
                end
                default: begin
                    xsum = xsum ^ b;
                    if (pos >= flen) begin
                        if (xsum == 8'h00 && kind != ltm_pkg::KIND_N)
                            due_frames.push_back(decode_frame());
                        phase = ltm_pkg::PH_HUNT;
                    end else begin
                        store[pos] = b;
                        pos++;
                    end
                end
            endcase
        endfunction

        function string show(ltm_pkg::result_t r);
            return $sformatf("kind=%0d a=%h b=%h c=%h ba=%h bb=%h mode=%h arm=%b fs=%b hint=%b",
                             r.frame_kind, r.word_a, r.word_b, r.word_c, r.byte_a, r.byte_b,
                             r.mode_bits, r.armed_flag, r.failsafe_flag, r.render_hint);
        endfunction

        // one result transfer from the dut
        function void match_frame(ltm_pkg::result_t got);
            ltm_pkg::result_t want;
            if (due_frames.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("unexpected frame: %s", show(got));
                return;
            end
            want = due_frames.pop_front();
            if (want.frame_kind !== got.frame_kind || want.word_a !== got.word_a ||
                want.word_b !== got.word_b || want.word_c !== got.word_c ||
                want.byte_a !== got.byte_a || want.byte_b !== got.byte_b ||
                want.mode_bits !== got.mode_bits || want.armed_flag !== got.armed_flag ||
                want.failsafe_flag !== got.failsafe_flag ||
                want.render_hint !== got.render_hint) begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES) begin
                    $display("frame mismatch");
                    $display("  expected %s", show(want));
                    $display("  actual   %s", show(got));
                end
            end
        endfunction
    endclass

    // dut signals, the inputs all known from time zero
    logic                              aclk      = 1'b0;
    logic                              aresetn   = 1'b0;
    logic                              cfg_wr_en = 1'b0;
    logic [ltm_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
    logic [ltm_pkg::CFG_W-1:0]         cfg_data  = '0;
    logic                              s_valid   = 1'b0;
    logic                              s_ready;
    logic [7:0]                        s_rx_byte = 8'h00;
    logic                              m_valid;
    logic                              m_ready   = 1'b0;
    logic [ltm_pkg::KIND_W-1:0]        m_frame_kind;
    logic signed [31:0]                m_word_a;
    logic signed [31:0]                m_word_b;
    logic signed [31:0]                m_word_c;
    logic [7:0]                        m_byte_a;
    logic [7:0]                        m_byte_b;
    logic [5:0]                        m_mode_bits;
    logic                              m_armed_flag;
    logic                              m_failsafe_flag;
    logic                              m_render_hint;

    // set during one whole phase: neither side idles
    bit                                steady = 1'b0;

    ltm_frame_tracker                  tracker;

    ltm_telemetry_frame_parser_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_frame_kind    (m_frame_kind),
        .m_word_a        (m_word_a),
        .m_word_b        (m_word_b),
        .m_word_c        (m_word_c),
        .m_byte_a        (m_byte_a),
        .m_byte_b        (m_byte_b),
        .m_mode_bits     (m_mode_bits),
        .m_armed_flag    (m_armed_flag),
        .m_failsafe_flag (m_failsafe_flag),
        .m_render_hint   (m_render_hint)
    );

    // free-running clock
    initial begin
        forever #HALF_PERIOD aclk = ~aclk;
    end

    // hard stop in case a transfer never completes
    initial begin
        #(TIMEOUT_CYCLES * 2 * HALF_PERIOD);
        $display("[FAIL] regression broken");
        $finish;
    end

    // result side: ready drops now and then, never during the steady phase
    always @(posedge aclk) begin
        if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor, sampled values are the ones from before the edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_frame(ltm_pkg::result_t'{m_frame_kind, m_word_a, m_word_b,
                                                   m_word_c, m_byte_a, m_byte_b,
                                                   m_mode_bits, m_armed_flag,
                                                   m_failsafe_flag, m_render_hint});
        end
    end

    // one byte transfer on the stream side, sometimes with s_valid held low first
    task automatic push_byte(input logic [7:0] b);
        if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do @(posedge aclk); while (!s_ready);
        // transfer happened at this edge
        tracker.take_byte(b);
    endtask

    // header, letter, payload and check byte; a spoiled check byte is never right
    task automatic send_frame(input logic [7:0] letter, input logic [7:0] body [$],
                              input bit spoil);
        logic [7:0] sum;
        sum = 8'h00;
        push_byte(ltm_pkg::CHAR_DOLLAR);
        push_byte(ltm_pkg::CHAR_T);
        push_byte(letter);
        foreach (body[i]) begin
            sum = sum ^ body[i];
            push_byte(body[i]);
        end
        if (spoil) sum = sum ^ 8'($urandom_range(1, 255));
        push_byte(sum);
    endtask

    // payload bytes lean toward extremes and header characters
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(15))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h80;
            3:       return 8'h7F;
            4:       return ltm_pkg::CHAR_DOLLAR;
            5:       return ltm_pkg::CHAR_T;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(5))
            0:       return ltm_pkg::CHAR_G;
            1:       return ltm_pkg::CHAR_A;
            2:       return ltm_pkg::CHAR_S;
            3:       return ltm_pkg::CHAR_O;
            4:       return ltm_pkg::CHAR_N;
            default: return ltm_pkg::CHAR_X;
        endcase
    endfunction

    // loose bytes, broken headers and cut-off frames
    task automatic send_noise();
        int cut;
        case ($urandom_range(3))
            0: repeat ($urandom_range(1, 4)) push_byte(pick_byte());
            1: begin
                push_byte(ltm_pkg::CHAR_DOLLAR);
                push_byte(pick_byte());
            end
            2: begin
                push_byte(ltm_pkg::CHAR_DOLLAR);
                push_byte(ltm_pkg::CHAR_T);
                push_byte(8'($urandom_range(255)));
            end
            default: begin
                // cut-off frame, the next header lands in its payload
                push_byte(ltm_pkg::CHAR_DOLLAR);
                push_byte(ltm_pkg::CHAR_T);
                push_byte(pick_letter());
                cut = $urandom_range(0, 5);
                repeat (cut) push_byte(pick_byte());
            end
        endcase
    endtask

    // leave the parser hunting and let every owed frame come out
    task automatic settle_parser();
        while (tracker.phase != ltm_pkg::PH_HUNT) push_byte(8'h00);
        s_valid <= 1'b0;
        while (tracker.due_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_len(input logic [ltm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ltm_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        tracker.set_len(idx, val);
    endtask

    initial begin
        logic [7:0]                body [$];
        logic [ltm_pkg::CFG_W-1:0] lens [6];
        logic [7:0]                letter;
        int                        sent;
        int                        n;

        tracker = new();

        // synchronous reset, released once
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: bad header byte after the dollar sign
        push_byte(ltm_pkg::CHAR_DOLLAR);
        push_byte(ltm_pkg::CHAR_X);
        // unknown frame letter
        push_byte(ltm_pkg::CHAR_DOLLAR);
        push_byte(ltm_pkg::CHAR_T);
        push_byte(CHAR_BOGUS);
        // a dollar sign in the letter slot is not a new frame start
        push_byte(ltm_pkg::CHAR_DOLLAR);
        push_byte(ltm_pkg::CHAR_T);
        push_byte(ltm_pkg::CHAR_DOLLAR);
        push_byte(ltm_pkg::CHAR_T);
        // attitude frame: most negative pitch, most positive roll, heading -1
        body = '{8'h00, 8'h80, 8'hFF, 8'h7F, 8'hFF, 8'hFF};
        send_frame(ltm_pkg::CHAR_A, body, 1'b0);

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            // length settings: reset values, the extremes, then mixes
            if (ph > 0) begin
                case (ph)
                    1:       foreach (lens[i]) lens[i] = 4'd15;
                    2:       foreach (lens[i]) lens[i] = 4'd0;
                    3:       foreach (lens[i]) lens[i] = 4'd1;
                    4:       foreach (lens[i]) lens[i] = 4'd14;
                    5:       lens = '{4'd2, 4'd5, 4'd0, 4'd15, 4'd3, 4'd9};
                    default: foreach (lens[i]) lens[i] = 4'($urandom_range(15));
                endcase
                settle_parser();
                write_len(ltm_pkg::REG_GPS_LEN,      lens[0]);
                write_len(ltm_pkg::REG_ATTITUDE_LEN, lens[1]);
                write_len(ltm_pkg::REG_SENSOR_LEN,   lens[2]);
                write_len(ltm_pkg::REG_ORIGIN_LEN,   lens[3]);
                write_len(ltm_pkg::REG_NAV_LEN,      lens[4]);
                write_len(ltm_pkg::REG_EXTRA_LEN,    lens[5]);
                if (ph == 5) begin
                    // writes past the register list change nothing
                    write_len(REG_SPARE_LO, 4'($urandom_range(15)));
                    write_len(REG_SPARE_HI, 4'($urandom_range(15)));
                end
                cfg_wr_en <= 1'b0;
            end
            steady = (ph == STEADY_PHASE);

            // mostly well-formed frames with random payload, some noise between
            sent = 0;
            while (sent < FRAME_BYTE_BUDGET / PHASE_COUNT) begin
                if ($urandom_range(99) < GOOD_PERCENT) begin
                    letter = pick_letter();
                    n      = tracker.frame_len(letter);
                    body.delete();
                    repeat (n) body.push_back(pick_byte());
                    send_frame(letter, body, $urandom_range(99) < SPOIL_PERCENT);
                    sent += n + 4;
                end else begin
                    send_noise();
                end
            end
        end
        steady = 1'b0;

        // drain: every owed frame out, then a settle wait for strays
        s_valid <= 1'b0;
        while (tracker.due_frames.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (tracker.mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/ltm_pkg.sv
src/ltm_field_unpack.sv
src/ltm_telemetry_frame_parser_top.sv
verif/tb_top.sv
